/* rtl/rpos_pkg.sv */
// Package with the sizes, opcodes and status codes of the row profile overlap search.
`timescale 1ns / 1ps
package rpos_pkg;

    localparam int MAX_ROWS   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int CNT_W      = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W     = $clog2(MAX_ROWS);
    localparam int ACC_W      = 2 * VALUE_BITS + ADDR_W;
    localparam int P_W        = 2 * ACC_W;
    localparam int PW         = 2 * P_W;
    localparam int MUL_CNT_W  = $clog2(P_W);
    localparam int POS_W      = 10;
    localparam int VAR_W      = 32;

    typedef enum logic [1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FLAT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_OVERLAP  = 2'd0,
        CFG_MAX_OVERLAP  = 2'd1,
        CFG_MIN_VARIANCE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

endpackage

/* rtl/row_profile_overlap_search.sv */
// Row profile overlap search: sequence stores, sequencer and shared serial multiplier.
`timescale 1ns / 1ps
// Appends, and searches that fail the empty or range check, finish without raising busy;
// for such a search done is strobed in the cycle after the accepting edge, appends give no
// done. A full search runs the flatness tests, then per overlap length L the row reads
// and one to five runs of the shift-add multiplier. busy is high throughout; results cannot
// be stalled. rst_n clears counts and control and loads the default configuration.
module row_profile_overlap_search
    import rpos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            opcode,
    input  logic [VALUE_BITS-1:0] row_value,
    output logic                  done,
    output logic                  found,
    output logic [POS_W-1:0]      match_position,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [VAR_W-1:0]      cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_FL_RD, S_FL_ACC, S_V_NN, S_V_MV, S_V_S1, S_V_NS, S_V_CMP,
        S_OV_START, S_OV_RD, S_OV_AB, S_OV_AA, S_OV_BB, S_OV_P, S_OV_DEC,
        S_OV_L1, S_OV_R1, S_OV_R2, S_OV_CMP, S_OV_UPD, S_OV_NEXT, S_MUL
    } state_t;

    state_t                  state_reg, ret_reg;
    logic [CNT_W-1:0]        count_a_reg, count_b_reg;
    logic [CNT_W-1:0]        min_ov_reg, max_ov_reg;
    logic [VAR_W-1:0]        min_var_reg;
    logic                    done_reg, found_reg;
    logic [POS_W-1:0]        pos_out_reg;
    status_t                 status_reg;
    logic                    side_reg;
    logic [ADDR_W-1:0]       idx_reg, start_reg, best_pos_reg;
    logic [CNT_W-1:0]        len_reg, range_reg;
    logic [ACC_W-1:0]        dot_reg, na_reg, nb_reg, best_dot_reg;
    logic [P_W-1:0]          p_reg, best_p_reg;
    logic                    zero_reg, have_reg, best_zero_reg;
    logic [PW-1:0]           rhs_reg, l_reg;
    logic [PW-1:0]           mul_x_reg, mul_acc_reg;
    logic [P_W-1:0]          mul_y_reg;
    logic [MUL_CNT_W-1:0]    mul_cnt_reg;

    logic [VALUE_BITS-1:0]   mem_a [MAX_ROWS];
    logic [VALUE_BITS-1:0]   mem_b [MAX_ROWS];
    logic [VALUE_BITS-1:0]   rd_a_reg, rd_b_reg;

    logic                    accept;
    logic [CNT_W-1:0]        range_c, lo_c, fl_n;
    logic [ADDR_W-1:0]       addr_a, addr_b;
    logic [VALUE_BITS-1:0]   sm_x, sm_y, fl_v;
    logic [2*VALUE_BITS-1:0] sm_prod;
    logic                    ov_zero;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done           = done_reg;
    assign found          = found_reg;
    assign match_position = pos_out_reg;
    assign status         = status_reg;

    always_comb
    begin
        range_c = max_ov_reg;
        if (count_a_reg < range_c)
        begin
            range_c = count_a_reg;
        end
        if (count_b_reg < range_c)
        begin
            range_c = count_b_reg;
        end
        lo_c = (min_ov_reg == '0) ? CNT_W'(1) : min_ov_reg;
    end

    assign fl_n = side_reg ? count_b_reg : count_a_reg;
    assign fl_v = side_reg ? rd_b_reg : rd_a_reg;
    assign ov_zero = (na_reg == '0) || (nb_reg == '0) || (dot_reg == '0);

    // hold the tail address of A for the whole row step, since the read reloads every cycle
    always_comb
    begin
        if (state_reg == S_OV_RD || state_reg == S_OV_AB || state_reg == S_OV_AA
            || state_reg == S_OV_BB)
        begin
            addr_a = start_reg + idx_reg;
        end
        else
        begin
            addr_a = idx_reg;
        end
        addr_b = idx_reg;
    end

    // One small multiplier serves every per-row product.
    always_comb
    begin
        case (state_reg)
            S_OV_AB:
            begin
                sm_x = rd_a_reg;
                sm_y = rd_b_reg;
            end
            S_OV_AA:
            begin
                sm_x = rd_a_reg;
                sm_y = rd_a_reg;
            end
            S_OV_BB:
            begin
                sm_x = rd_b_reg;
                sm_y = rd_b_reg;
            end
            default:
            begin
                sm_x = fl_v;
                sm_y = fl_v;
            end
        endcase
        sm_prod = sm_x * sm_y;
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_APPEND_A && count_a_reg < CNT_W'(MAX_ROWS))
        begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= row_value;
        end
        if (accept && opcode == OP_APPEND_B && count_b_reg < CNT_W'(MAX_ROWS))
        begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= row_value;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            min_ov_reg    <= CNT_W'(1);
            max_ov_reg    <= CNT_W'(1024);
            min_var_reg   <= VAR_W'(65536);
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            pos_out_reg   <= '0;
            status_reg    <= ST_OK;
            side_reg      <= 1'b0;
            have_reg      <= 1'b0;
            best_zero_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_OVERLAP:  min_ov_reg  <= cfg_data[CNT_W-1:0];
                    CFG_MAX_OVERLAP:  max_ov_reg  <= cfg_data[CNT_W-1:0];
                    CFG_MIN_VARIANCE: min_var_reg <= cfg_data;
                    default:          ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode)
                            OP_APPEND_A:
                            begin
                                if (count_a_reg < CNT_W'(MAX_ROWS))
                                begin
                                    count_a_reg <= count_a_reg + CNT_W'(1);
                                end
                            end
                            OP_APPEND_B:
                            begin
                                if (count_b_reg < CNT_W'(MAX_ROWS))
                                begin
                                    count_b_reg <= count_b_reg + CNT_W'(1);
                                end
                            end
                            OP_SEARCH:
                            begin
                                if (count_a_reg == '0 || count_b_reg == '0)
                                begin
                                    done_reg    <= 1'b1;
                                    found_reg   <= 1'b0;
                                    pos_out_reg <= '0;
                                    status_reg  <= ST_EMPTY;
                                    count_a_reg <= '0;
                                    count_b_reg <= '0;
                                end
                                else if (range_c < min_ov_reg || range_c < lo_c)
                                begin
                                    done_reg    <= 1'b1;
                                    found_reg   <= 1'b0;
                                    pos_out_reg <= '0;
                                    status_reg  <= ST_RANGE;
                                    count_a_reg <= '0;
                                    count_b_reg <= '0;
                                end
                                else
                                begin
                                    range_reg <= range_c;
                                    len_reg   <= lo_c;
                                    side_reg  <= 1'b0;
                                    idx_reg   <= '0;
                                    dot_reg   <= '0;
                                    na_reg    <= '0;
                                    state_reg <= S_FL_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FL_RD:
                begin
                    state_reg <= S_FL_ACC;
                end
                S_FL_ACC:
                begin
                    // dot_reg holds the plain sum, na_reg the sum of squares
                    dot_reg <= dot_reg + ACC_W'(fl_v);
                    na_reg  <= na_reg + ACC_W'(sm_prod);
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (CNT_W'(idx_reg) == fl_n - CNT_W'(1))
                    begin
                        state_reg <= S_V_NN;
                    end
                    else
                    begin
                        state_reg <= S_FL_RD;
                    end
                end
                S_V_NN:
                begin
                    mul_x_reg   <= PW'(fl_n);
                    mul_y_reg   <= P_W'(fl_n);
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_V_MV;
                    state_reg   <= S_MUL;
                end
                S_V_MV:
                begin
                    mul_x_reg   <= PW'(min_var_reg);
                    mul_y_reg   <= mul_acc_reg[P_W-1:0];
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_V_S1;
                    state_reg   <= S_MUL;
                end
                S_V_S1:
                begin
                    rhs_reg     <= mul_acc_reg;
                    mul_x_reg   <= PW'(dot_reg);
                    mul_y_reg   <= P_W'(dot_reg);
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_V_NS;
                    state_reg   <= S_MUL;
                end
                S_V_NS:
                begin
                    rhs_reg     <= rhs_reg + mul_acc_reg;
                    mul_x_reg   <= PW'(na_reg);
                    mul_y_reg   <= P_W'(fl_n);
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_V_CMP;
                    state_reg   <= S_MUL;
                end
                S_V_CMP:
                begin
                    if (mul_acc_reg < rhs_reg)
                    begin
                        done_reg    <= 1'b1;
                        found_reg   <= 1'b0;
                        pos_out_reg <= '0;
                        status_reg  <= ST_FLAT;
                        count_a_reg <= '0;
                        count_b_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else if (!side_reg)
                    begin
                        side_reg  <= 1'b1;
                        idx_reg   <= '0;
                        dot_reg   <= '0;
                        na_reg    <= '0;
                        state_reg <= S_FL_RD;
                    end
                    else
                    begin
                        have_reg  <= 1'b0;
                        state_reg <= S_OV_START;
                    end
                end
                S_OV_START:
                begin
                    start_reg <= ADDR_W'(count_a_reg - len_reg);
                    idx_reg   <= '0;
                    dot_reg   <= '0;
                    na_reg    <= '0;
                    nb_reg    <= '0;
                    state_reg <= S_OV_RD;
                end
                S_OV_RD:
                begin
                    state_reg <= S_OV_AB;
                end
                S_OV_AB:
                begin
                    dot_reg   <= dot_reg + ACC_W'(sm_prod);
                    state_reg <= S_OV_AA;
                end
                S_OV_AA:
                begin
                    na_reg    <= na_reg + ACC_W'(sm_prod);
                    state_reg <= S_OV_BB;
                end
                S_OV_BB:
                begin
                    nb_reg  <= nb_reg + ACC_W'(sm_prod);
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (CNT_W'(idx_reg) == len_reg - CNT_W'(1))
                    begin
                        state_reg <= S_OV_P;
                    end
                    else
                    begin
                        state_reg <= S_OV_RD;
                    end
                end
                S_OV_P:
                begin
                    mul_x_reg   <= PW'(na_reg);
                    mul_y_reg   <= P_W'(nb_reg);
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_OV_DEC;
                    state_reg   <= S_MUL;
                end
                S_OV_DEC:
                begin
                    p_reg    <= mul_acc_reg[P_W-1:0];
                    zero_reg <= ov_zero;
                    if (!have_reg)
                    begin
                        state_reg <= S_OV_UPD;
                    end
                    else if (ov_zero)
                    begin
                        state_reg <= S_OV_NEXT;
                    end
                    else if (best_zero_reg)
                    begin
                        state_reg <= S_OV_UPD;
                    end
                    else
                    begin
                        mul_x_reg   <= PW'(dot_reg);
                        mul_y_reg   <= P_W'(dot_reg);
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        ret_reg     <= S_OV_L1;
                        state_reg   <= S_MUL;
                    end
                end
                S_OV_L1:
                begin
                    mul_x_reg   <= mul_acc_reg;
                    mul_y_reg   <= best_p_reg;
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_OV_R1;
                    state_reg   <= S_MUL;
                end
                S_OV_R1:
                begin
                    l_reg       <= mul_acc_reg;
                    mul_x_reg   <= PW'(best_dot_reg);
                    mul_y_reg   <= P_W'(best_dot_reg);
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_OV_R2;
                    state_reg   <= S_MUL;
                end
                S_OV_R2:
                begin
                    mul_x_reg   <= mul_acc_reg;
                    mul_y_reg   <= p_reg;
                    mul_acc_reg <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= S_OV_CMP;
                    state_reg   <= S_MUL;
                end
                S_OV_CMP:
                begin
                    if (l_reg > mul_acc_reg)
                    begin
                        state_reg <= S_OV_UPD;
                    end
                    else
                    begin
                        state_reg <= S_OV_NEXT;
                    end
                end
                S_OV_UPD:
                begin
                    have_reg      <= 1'b1;
                    best_zero_reg <= zero_reg;
                    best_dot_reg  <= dot_reg;
                    best_p_reg    <= p_reg;
                    best_pos_reg  <= start_reg;
                    state_reg     <= S_OV_NEXT;
                end
                S_OV_NEXT:
                begin
                    if (len_reg == range_reg)
                    begin
                        done_reg    <= 1'b1;
                        found_reg   <= 1'b1;
                        pos_out_reg <= POS_W'(best_pos_reg);
                        status_reg  <= ST_OK;
                        count_a_reg <= '0;
                        count_b_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        len_reg   <= len_reg + CNT_W'(1);
                        state_reg <= S_OV_START;
                    end
                end
                S_MUL:
                begin
                    // shift-add: one multiplier bit per cycle
                    if (mul_y_reg[0])
                    begin
                        mul_acc_reg <= mul_acc_reg + mul_x_reg;
                    end
                    mul_x_reg   <= mul_x_reg << 1;
                    mul_y_reg   <= mul_y_reg >> 1;
                    mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
                    if (mul_cnt_reg == MUL_CNT_W'(P_W - 1))
                    begin
                        state_reg <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == ST_OK)
        else $error("found without ok status");
    a_count_a: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(MAX_ROWS) && count_b_reg <= CNT_W'(MAX_ROWS))
        else $error("sequence count beyond store depth");
    a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && opcode == OP_SEARCH))
        else $error("busy rose without a search transaction");
`endif

endmodule
